// ===== rtl/i2cbs_pkg.sv =====
package i2cbs_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICKS_PER_US = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [9:0] TICKS_PER_US_RST = 10'd100;
    localparam logic [9:0] ACK_TIMEOUT_RST  = 10'd250;

    // Command codes carried in the mode field.
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_WACK  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    // Bits in one data byte.
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // One tick of input.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } cmd_t;

    // One tick of result.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } res_t;

endpackage

// ===== rtl/i2cbs_core.sv =====
module i2cbs_core
    import i2cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  cmd_t       item,
    input  logic [9:0] ticks_per_us,
    input  logic [9:0] ack_timeout,
    output res_t       result
);

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_WR_SET  = 4'd5;
    localparam logic [3:0] PH_WR_HIGH = 4'd6;
    localparam logic [3:0] PH_WR_LOW  = 4'd7;
    localparam logic [3:0] PH_WA_A    = 4'd8;
    localparam logic [3:0] PH_WA_POLL = 4'd9;
    localparam logic [3:0] PH_RD_LOW  = 4'd10;
    localparam logic [3:0] PH_RD_HIGH = 4'd11;
    localparam logic [3:0] PH_AK_A    = 4'd12;
    localparam logic [3:0] PH_AK_B    = 4'd13;

    logic [3:0]  phase_reg,       phase_next;
    logic [3:0]  bit_index_reg,   bit_index_next;
    logic [11:0] delay_count_reg, delay_count_next;
    logic [7:0]  shift_reg_reg,   shift_reg_next;
    logic [9:0]  wait_count_reg,  wait_count_next;
    logic        scl_reg,         scl_next;
    logic        sda_reg,         sda_next;
    logic        fail_flag_reg,   fail_flag_next;
    logic        ack_choice_reg,  ack_choice_next;
    logic [7:0]  rx_hold_reg,     rx_hold_next;
    logic        done;

    logic [9:0]  tick_us;
    logic [11:0] hold1;
    logic [11:0] hold2;
    logic [11:0] hold4;
    logic [3:0]  bit_inc;

    // Hold lengths in ticks, minus the tick that sets the levels.
    assign tick_us = (ticks_per_us == 10'd0) ? 10'd1 : ticks_per_us;
    assign hold1   = {2'b00, tick_us} - 12'd1;
    assign hold2   = {1'b0, tick_us, 1'b0} - 12'd1;
    assign hold4   = {tick_us, 2'b00} - 12'd1;
    assign bit_inc = bit_index_reg + 4'd1;

    // Next state of the sequencer for one tick.
    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        delay_count_next = delay_count_reg;
        shift_reg_next   = shift_reg_reg;
        wait_count_next  = wait_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        fail_flag_next   = fail_flag_reg;
        ack_choice_next  = ack_choice_reg;
        rx_hold_next     = rx_hold_reg;
        done             = 1'b0;

        priority if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid && item.mode <= MODE_READ)
            begin
                bit_index_next = 4'd0;
                unique case (item.mode)
                    MODE_START:
                    begin
                        sda_next         = 1'b1;
                        scl_next         = 1'b1;
                        delay_count_next = hold4;
                        phase_next       = PH_ST_A;
                    end
                    MODE_STOP:
                    begin
                        scl_next         = 1'b0;
                        sda_next         = 1'b0;
                        delay_count_next = hold4;
                        phase_next       = PH_SP_A;
                    end
                    MODE_WRITE:
                    begin
                        scl_next         = 1'b0;
                        sda_next         = item.tx_byte[7];
                        shift_reg_next   = {item.tx_byte[6:0], 1'b0};
                        delay_count_next = hold2;
                        phase_next       = PH_WR_SET;
                    end
                    MODE_WACK:
                    begin
                        fail_flag_next   = 1'b0;
                        wait_count_next  = 10'd0;
                        sda_next         = 1'b1;
                        delay_count_next = hold1;
                        phase_next       = PH_WA_A;
                    end
                    default:
                    begin
                        ack_choice_next  = item.send_ack;
                        shift_reg_next   = 8'd0;
                        sda_next         = 1'b1;
                        scl_next         = 1'b0;
                        delay_count_next = hold2;
                        phase_next       = PH_RD_LOW;
                    end
                endcase
            end
        end
        else if (delay_count_reg != 12'd0)
        begin
            delay_count_next = delay_count_reg - 12'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    sda_next         = 1'b0;
                    delay_count_next = hold4;
                    phase_next       = PH_ST_B;
                end
                PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_next         = 1'b1;
                    delay_count_next = hold4;
                    phase_next       = PH_SP_B;
                end
                PH_SP_B:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_WR_SET:
                begin
                    scl_next         = 1'b1;
                    delay_count_next = hold2;
                    phase_next       = PH_WR_HIGH;
                end
                PH_WR_HIGH:
                begin
                    scl_next         = 1'b0;
                    delay_count_next = hold2;
                    phase_next       = PH_WR_LOW;
                end
                PH_WR_LOW:
                begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= BYTE_BITS)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        sda_next         = shift_reg_reg[7];
                        shift_reg_next   = {shift_reg_reg[6:0], 1'b0};
                        delay_count_next = hold2;
                        phase_next       = PH_WR_SET;
                    end
                end
                PH_WA_A:
                begin
                    scl_next         = 1'b1;
                    delay_count_next = hold1;
                    phase_next       = PH_WA_POLL;
                end
                PH_WA_POLL:
                begin
                    if (!item.sda_in)
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else if (wait_count_reg >= ack_timeout)
                    begin
                        // Timed out: flag it and release the bus with a stop.
                        fail_flag_next   = 1'b1;
                        scl_next         = 1'b0;
                        sda_next         = 1'b0;
                        delay_count_next = hold4;
                        phase_next       = PH_SP_A;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg + 10'd1;
                    end
                end
                PH_RD_LOW:
                begin
                    scl_next         = 1'b1;
                    shift_reg_next   = {shift_reg_reg[6:0], item.sda_in};
                    delay_count_next = hold1;
                    phase_next       = PH_RD_HIGH;
                end
                PH_RD_HIGH:
                begin
                    bit_index_next   = bit_inc;
                    scl_next         = 1'b0;
                    delay_count_next = hold2;
                    if (bit_inc < BYTE_BITS)
                    begin
                        phase_next = PH_RD_LOW;
                    end
                    else
                    begin
                        rx_hold_next = shift_reg_reg;
                        sda_next     = ~ack_choice_reg;
                        phase_next   = PH_AK_A;
                    end
                end
                PH_AK_A:
                begin
                    scl_next         = 1'b1;
                    delay_count_next = hold2;
                    phase_next       = PH_AK_B;
                end
                PH_AK_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // The result of this tick reflects the updated state.
    always_comb
    begin
        result.scl_level  = scl_next;
        result.sda_level  = sda_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.rx_byte    = rx_hold_next;
        result.ack_failed = fail_flag_next;
    end

    // State registers advance only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= 4'd0;
            delay_count_reg <= 12'd0;
            shift_reg_reg   <= 8'd0;
            wait_count_reg  <= 10'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            fail_flag_reg   <= 1'b0;
            ack_choice_reg  <= 1'b0;
            rx_hold_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            delay_count_reg <= delay_count_next;
            shift_reg_reg   <= shift_reg_next;
            wait_count_reg  <= wait_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            fail_flag_reg   <= fail_flag_next;
            ack_choice_reg  <= ack_choice_next;
            rx_hold_reg     <= rx_hold_next;
        end
    end

endmodule

// ===== rtl/i2cbs_out_reg.sv =====
module i2cbs_out_reg
    import i2cbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t load_data,
    output logic busy,
    input  logic out_stall,
    output logic out_valid,
    output res_t out_data
);

    logic valid_reg;
    res_t data_reg;

    // A new result may enter when the held one is gone or leaves now.
    assign busy      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid flag of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// Channel | Direction | Handshake            | Payload
// in      | request   | in_valid / in_stall  | in_data  (cmd_t, one bus tick)
// out     | result    | out_valid / out_stall| out_data (res_t, one per tick)
// cfg     | write     | cfg_we               | cfg_index, cfg_data
//
// One request is taken every cycle unless in_stall holds it off; its result appears in the output
// register on the next cycle.
// The rate is set by the combinational sequencer update feeding the result register.
// Reset is asynchronous and active low; the bus lines come out released.
// A stalled result holds; a request is taken alongside it only when it drains.
module i2c_master_bit_sequencer_top
    import i2cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  cmd_t       in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output res_t       out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    logic [9:0] ticks_per_us_reg;
    logic [9:0] ack_timeout_reg;
    logic       accept;
    logic       out_busy;
    res_t       step_res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg <= TICKS_PER_US_RST;
            ack_timeout_reg  <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TICKS_PER_US)
            begin
                ticks_per_us_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_data;
            end
        end
    end

    // A request is taken whenever the result register can take its result.
    assign in_stall = out_busy;
    assign accept   = in_valid && !out_busy;

    i2cbs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .item         (in_data),
        .ticks_per_us (ticks_per_us_reg),
        .ack_timeout  (ack_timeout_reg),
        .result       (step_res)
    );

    i2cbs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_res),
        .busy      (out_busy),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== bench/i2c_master_bit_sequencer_top_tb.sv =====
module i2c_master_bit_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbs_pkg::*;

    localparam int CYCLE_LIMIT = 40_000;
    localparam int RANDOM_ITEMS = 150;
    localparam int LONG_HOLD = 400;
    localparam logic [2:0] MODE_TOP_CODE = 3'd7;

    // Sequencer steps of the bus predictor.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START_A,
        ST_START_B,
        ST_STOP_A,
        ST_STOP_B,
        ST_WR_SET,
        ST_WR_HIGH,
        ST_WR_LOW,
        ST_WA_SETUP,
        ST_WA_POLL,
        ST_RD_LOW,
        ST_RD_HIGH,
        ST_ACK_A,
        ST_ACK_B
    } bus_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    cmd_t       in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    res_t       out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    // Predictor copy of the configuration and the sequencer state.
    logic [9:0]  us_ticks = TICKS_PER_US_RST;
    logic [9:0]  ack_limit = ACK_TIMEOUT_RST;
    bus_state_t  seq_st = ST_IDLE;
    logic [3:0]  bit_cnt = '0;
    logic [11:0] delay_left = '0;
    logic [7:0]  shifter = '0;
    logic [9:0]  poll_cnt = '0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    logic        timed_out = 1'b0;
    logic        ack_drive = 1'b0;
    logic [7:0]  last_rx = '0;

    res_t pending_res[$];
    res_t want;
    int   errors = 0;
    int   cycle_cnt = 0;
    int   items_sent = 0;
    int   send_gap_pct = 0;
    int   recv_stall_pct = 0;
    int   stall_hold_left = 0;

    i2c_master_bit_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // A hold of the given microseconds, less the tick that sets the levels.
    function automatic logic [11:0] hold_ticks(input int unsigned us);
        int unsigned eff;
        eff = (us_ticks == 10'd0) ? 1 : us_ticks;
        return 12'(us * eff - 1);
    endfunction

    task automatic start_stop_seq();
        scl_q = 1'b0;
        sda_q = 1'b0;
        delay_left = hold_ticks(4);
        seq_st = ST_STOP_A;
    endtask

    task automatic load_next_bit();
        sda_q = shifter[7];
        shifter = {shifter[6:0], 1'b0};
        delay_left = hold_ticks(2);
        seq_st = ST_WR_SET;
    endtask

    // Advance the predicted bus by one tick and form the result it produces.
    task automatic advance_bus(input cmd_t c, output res_t r);
        logic finished;
        finished = 1'b0;
        if (seq_st == ST_IDLE)
        begin
            if (c.cmd_valid && c.mode <= MODE_READ)
            begin
                bit_cnt = '0;
                case (c.mode)
                    MODE_START:
                    begin
                        sda_q = 1'b1;
                        scl_q = 1'b1;
                        delay_left = hold_ticks(4);
                        seq_st = ST_START_A;
                    end
                    MODE_STOP:
                    begin
                        start_stop_seq();
                    end
                    MODE_WRITE:
                    begin
                        scl_q = 1'b0;
                        shifter = c.tx_byte;
                        load_next_bit();
                    end
                    MODE_WACK:
                    begin
                        timed_out = 1'b0;
                        poll_cnt = '0;
                        sda_q = 1'b1;
                        delay_left = hold_ticks(1);
                        seq_st = ST_WA_SETUP;
                    end
                    default:
                    begin
                        ack_drive = c.send_ack;
                        shifter = '0;
                        sda_q = 1'b1;
                        scl_q = 1'b0;
                        delay_left = hold_ticks(2);
                        seq_st = ST_RD_LOW;
                    end
                endcase
            end
        end
        else if (delay_left != 12'd0)
        begin
            delay_left = delay_left - 12'd1;
        end
        else
        begin
            case (seq_st)
                ST_START_A:
                begin
                    sda_q = 1'b0;
                    delay_left = hold_ticks(4);
                    seq_st = ST_START_B;
                end
                ST_START_B:
                begin
                    scl_q = 1'b0;
                    seq_st = ST_IDLE;
                    finished = 1'b1;
                end
                ST_STOP_A:
                begin
                    scl_q = 1'b1;
                    delay_left = hold_ticks(4);
                    seq_st = ST_STOP_B;
                end
                ST_STOP_B:
                begin
                    sda_q = 1'b1;
                    seq_st = ST_IDLE;
                    finished = 1'b1;
                end
                ST_WR_SET:
                begin
                    scl_q = 1'b1;
                    delay_left = hold_ticks(2);
                    seq_st = ST_WR_HIGH;
                end
                ST_WR_HIGH:
                begin
                    scl_q = 1'b0;
                    delay_left = hold_ticks(2);
                    seq_st = ST_WR_LOW;
                end
                ST_WR_LOW:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BYTE_BITS)
                    begin
                        seq_st = ST_IDLE;
                        finished = 1'b1;
                    end
                    else
                    begin
                        load_next_bit();
                    end
                end
                ST_WA_SETUP:
                begin
                    scl_q = 1'b1;
                    delay_left = hold_ticks(1);
                    seq_st = ST_WA_POLL;
                end
                ST_WA_POLL:
                begin
                    // Low SDA is the acknowledge; a high line past the limit gives up.
                    if (!c.sda_in)
                    begin
                        scl_q = 1'b0;
                        seq_st = ST_IDLE;
                        finished = 1'b1;
                    end
                    else if (poll_cnt >= ack_limit)
                    begin
                        timed_out = 1'b1;
                        start_stop_seq();
                    end
                    else
                    begin
                        poll_cnt = poll_cnt + 10'd1;
                    end
                end
                ST_RD_LOW:
                begin
                    scl_q = 1'b1;
                    shifter = {shifter[6:0], c.sda_in};
                    delay_left = hold_ticks(1);
                    seq_st = ST_RD_HIGH;
                end
                ST_RD_HIGH:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    scl_q = 1'b0;
                    if (bit_cnt < BYTE_BITS)
                    begin
                        delay_left = hold_ticks(2);
                        seq_st = ST_RD_LOW;
                    end
                    else
                    begin
                        last_rx = shifter;
                        sda_q = !ack_drive;
                        delay_left = hold_ticks(2);
                        seq_st = ST_ACK_A;
                    end
                end
                ST_ACK_A:
                begin
                    scl_q = 1'b1;
                    delay_left = hold_ticks(2);
                    seq_st = ST_ACK_B;
                end
                ST_ACK_B:
                begin
                    scl_q = 1'b0;
                    seq_st = ST_IDLE;
                    finished = 1'b1;
                end
                default:
                begin
                    seq_st = ST_IDLE;
                end
            endcase
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res = (seq_st != ST_IDLE);
        r.done_res = finished;
        r.rx_byte = last_rx;
        r.ack_failed = timed_out;
    endtask

    // Offer one request, wait for it to be taken, then predict its result.
    task automatic offer_tick(input cmd_t c);
        res_t r;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
        advance_bus(c, r);
        pending_res.push_back(r);
    endtask

    // Level that the bus slave puts on SDA for the coming tick.
    function automatic logic line_level(input logic [7:0] line_byte, input int ack_after);
        if (seq_st == ST_RD_LOW)
            return line_byte[3'd7 - bit_cnt[2:0]];
        if (seq_st == ST_WA_POLL)
            return !(ack_after >= 0 && int'(poll_cnt) >= ack_after);
        return 1'($urandom_range(1));
    endfunction

    // Number of high polls before the acknowledge, or -1 for none at all.
    function automatic int pick_ack();
        return ($urandom_range(3) == 0) ? -1 : int'($urandom_range(ack_limit));
    endfunction

    // Issue one command while idle and tick the bus until it has finished.
    // Ticks in between carry random requests that the busy block must ignore.
    task automatic run_cmd(input logic [2:0] mode, input logic [7:0] tx, input logic sack,
                           input logic [7:0] line_byte, input int ack_after);
        cmd_t c;
        logic [$bits(cmd_t)-1:0] raw;
        c.cmd_valid = 1'b1;
        c.mode = mode;
        c.tx_byte = tx;
        c.send_ack = sack;
        c.sda_in = line_level(line_byte, ack_after);
        offer_tick(c);
        while (seq_st != ST_IDLE)
        begin
            raw = $bits(cmd_t)'($urandom);
            c = cmd_t'(raw);
            c.cmd_valid = ($urandom_range(3) == 0);
            c.sda_in = line_level(line_byte, ack_after);
            offer_tick(c);
        end
    endtask

    task automatic idle_ticks(input int n);
        cmd_t c;
        logic [$bits(cmd_t)-1:0] raw;
        for (int i = 0; i < n; i++)
        begin
            raw = $bits(cmd_t)'($urandom);
            c = cmd_t'(raw);
            c.cmd_valid = 1'b0;
            offer_tick(c);
        end
    endtask

    // Register write, only once every predicted result has been checked.
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        in_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_TICKS_PER_US)
            us_ticks = val;
        else
            ack_limit = val;
    endtask

    // Reset levels and the default microsecond count.
    task automatic test_reset_defaults();
        idle_ticks(4);
        run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, 0);
    endtask

    // Each command, extreme bytes, both acknowledge outcomes and unknown codes.
    task automatic test_directed_commands();
        write_reg(CFG_TICKS_PER_US, 10'd1);
        write_reg(CFG_ACK_TIMEOUT, 10'd0);
        run_cmd(MODE_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(MODE_WRITE, 8'hFF, 1'b0, 8'h00, 0);
        run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(MODE_WRITE, 8'h00, 1'b1, 8'hFF, 0);
        run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, -1);
        run_cmd(MODE_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(MODE_READ, 8'h00, 1'b1, 8'h00, 0);
        run_cmd(MODE_READ, 8'hFF, 1'b0, 8'hFF, 0);
        run_cmd(MODE_READ, 8'h3C, 1'b1, 8'h5A, 0);
        run_cmd(MODE_STOP, 8'h00, 1'b0, 8'h00, 0);
        for (int m = MODE_READ + 1; m <= MODE_TOP_CODE; m++)
            run_cmd(3'(m), 8'hA5, 1'b1, 8'h00, 0);
    endtask

    // Zero microsecond count and the largest acknowledge limit.
    task automatic test_timing_extremes();
        write_reg(CFG_TICKS_PER_US, 10'd0);
        run_cmd(MODE_WRITE, 8'hA5, 1'b0, 8'h00, 0);
        run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, 0);
        write_reg(CFG_ACK_TIMEOUT, 10'd1023);
        run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, 3);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_long_stall();
        write_reg(CFG_TICKS_PER_US, 10'd1);
        stall_hold_left = LONG_HOLD;
        run_cmd(MODE_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(MODE_WRITE, 8'($urandom), 1'b0, 8'h00, 0);
        run_cmd(MODE_STOP, 8'h00, 1'b0, 8'h00, 0);
    endtask

    // Mostly well-formed bus transfers with random content, some stray commands.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        int target;
        int n;
        logic [7:0] addr;
        bit fresh;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + RANDOM_ITEMS;
        fresh = 1'b1;
        while (items_sent < target)
        begin
            if (fresh || $urandom_range(24) == 0)
            begin
                write_reg(CFG_TICKS_PER_US, 10'($urandom_range(2)));
                write_reg(CFG_ACK_TIMEOUT, 10'($urandom_range(6)));
                fresh = 1'b0;
            end
            if ($urandom_range(9) == 0)
            begin
                run_cmd(3'($urandom_range(MODE_TOP_CODE)), 8'($urandom),
                        1'($urandom_range(1)), 8'($urandom), pick_ack());
            end
            else
            begin
                addr = 8'($urandom);
                n = $urandom_range(2, 1);
                run_cmd(MODE_START, 8'($urandom), 1'b0, 8'h00, 0);
                run_cmd(MODE_WRITE, addr, 1'b0, 8'h00, 0);
                run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, pick_ack());
                for (int k = 0; k < n; k++)
                begin
                    if (addr[0])
                    begin
                        run_cmd(MODE_READ, 8'($urandom), k != n - 1, 8'($urandom), 0);
                    end
                    else
                    begin
                        run_cmd(MODE_WRITE, 8'($urandom), 1'b0, 8'h00, 0);
                        run_cmd(MODE_WACK, 8'h00, 1'b0, 8'h00, pick_ack());
                    end
                end
                run_cmd(MODE_STOP, 8'($urandom), 1'b0, 8'h00, 0);
            end
            idle_ticks($urandom_range(2));
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endtask

    // Receiver stall: a long hold-off when requested, otherwise random.
    always @(negedge clk)
    begin
        if (stall_hold_left > 0)
        begin
            out_stall <= 1'b1;
            stall_hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_res.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(out_data.sda_level));
                check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
                check_field("rx_byte", want.rx_byte, out_data.rx_byte);
                check_field("ack_failed", 8'(want.ack_failed), 8'(out_data.ack_failed));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        send_gap_pct = 38;
        recv_stall_pct = 51;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_commands();
        test_timing_extremes();
        test_long_stall();
        test_random_traffic(38, 51);
        test_random_traffic(51, 38);
        test_random_traffic(0, 0);

        // Drain the remaining results, then allow for the output register.
        in_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
